/* hdl/dsr_pkg.sv */
// ============================================================================
// dsr_pkg - shared types and helpers for the nearest-neighbour downscaler
// Sizes, register map, controller states, port payloads and pixel functions.
// ============================================================================
package dsr_pkg;

   localparam int MAX_DIM = 4096;
   // Width that holds MAX_DIM itself, and width of a position counter
   localparam int DIM_W   = $clog2(MAX_DIM + 1);
   localparam int CNT_W   = $clog2(MAX_DIM);
   localparam int CFG_W   = 13;
   localparam int ADDR_W  = 5;
   localparam int IDX_W   = 3;
   localparam int DATA_W  = 32;
   localparam int DIV_CNT_W = $clog2(DIM_W + 1);

   localparam logic [IDX_W-1:0] REG_DST_WIDTH    = 3'd0;
   localparam logic [IDX_W-1:0] REG_DST_HEIGHT   = 3'd1;
   localparam logic [IDX_W-1:0] REG_SRC_WIDTH    = 3'd2;
   localparam logic [IDX_W-1:0] REG_SRC_HEIGHT   = 3'd3;
   localparam logic [IDX_W-1:0] REG_PIXEL_FORMAT = 3'd4;

   localparam logic [CFG_W-1:0] RST_DST_WIDTH  = 13'd320;
   localparam logic [CFG_W-1:0] RST_DST_HEIGHT = 13'd240;
   localparam logic [CFG_W-1:0] RST_SRC_WIDTH  = 13'd480;
   localparam logic [CFG_W-1:0] RST_SRC_HEIGHT = 13'd360;

   localparam logic FMT_RGB565   = 1'b0;
   localparam logic FMT_XRGB8888 = 1'b1;

   typedef enum logic [2:0] {
      ST_LOAD_COL,
      ST_WAIT_COL,
      ST_LOAD_ROW,
      ST_WAIT_ROW,
      ST_RUN
   } ctrl_state_type;

   typedef struct packed {
      logic [31:0] src_pixel;
      logic        frame_start;
   } req_type;

   typedef struct packed {
      logic [15:0] out_pixel;
      logic        frame_end;
   } rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0] dst_width;
      logic [CFG_W-1:0] dst_height;
      logic [CFG_W-1:0] src_width;
      logic [CFG_W-1:0] src_height;
      logic             pixel_format;
   } cfg_type;

   typedef struct packed {
      logic div_start;
      logic sel_row;
      logic latch_col;
      logic latch_row;
      logic run;
   } ctrl_cmd_type;

   typedef struct packed {
      logic cfg_written;
      logic div_done;
   } ctrl_status_type;

   typedef struct packed {
      logic [DIM_W-1:0] target;
      logic [DIM_W-1:0] rem;
   } adv_type;

   // Zero reads as one, anything above MAX_DIM as MAX_DIM
   function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
      logic [31:0] v32;
      v32 = 32'(v);
      if (v32 == 32'd0)
         return DIM_W'(1);
      else if (v32 > 32'(MAX_DIM))
         return DIM_W'(MAX_DIM);
      else
         return DIM_W'(v32);
   endfunction

   // Step a sampling target by s/d given as quotient and remainder.
   // Saturate at MAX_DIM: no position counter can ever reach it.
   function automatic adv_type advance(input logic [DIM_W-1:0] target,
                                       input logic [DIM_W-1:0] rem,
                                       input logic [DIM_W-1:0] q,
                                       input logic [DIM_W-1:0] r,
                                       input logic [DIM_W-1:0] d);
      logic [DIM_W:0] rem_sum;
      logic [DIM_W:0] tgt_sum;
      logic           carry;
      adv_type        res;
      rem_sum = {1'b0, rem} + {1'b0, r};
      carry   = (rem_sum >= {1'b0, d});
      res.rem = carry ? DIM_W'(rem_sum - {1'b0, d}) : DIM_W'(rem_sum);
      tgt_sum = {1'b0, target} + {1'b0, q} + (DIM_W+1)'(carry);
      if (tgt_sum >= (DIM_W+1)'(MAX_DIM))
         res.target = DIM_W'(MAX_DIM);
      else
         res.target = DIM_W'(tgt_sum);
      return res;
   endfunction

   function automatic logic [15:0] to_rgb565(input logic fmt, input logic [31:0] p);
      if (fmt == FMT_RGB565)
         return p[15:0];
      else
         return {p[23:19], p[15:10], p[7:3]};
   endfunction

endpackage

/* hdl/nearest_downscale_to_rgb565.sv */
// ============================================================================
// nearest_downscale_to_rgb565 - nearest-neighbour downscaler to RGB565
// Samples a raster-order source frame onto the destination grid and converts
// each kept pixel to RGB565.
// ============================================================================
//
//   channel   ports                         payload
//   --------  ----------------------------  ---------------------------------
//   request   req_valid / req_stall         req_type: src_pixel, frame_start
//   response  rsp_valid / rsp_stall         rsp_type: out_pixel, frame_end
//   config    psel penable pwrite paddr ..  13-bit sizes, 1-bit pixel format
//
// One source pixel per cycle unless the input stalls; a kept pixel appears at
// the response register in the cycle after its transfer. After reset and after
// every register write the input stalls while the shared iterative divider
// works out both frame ratios, one quotient bit per cycle. A response held by
// rsp_stall stalls the input; reset is synchronous and clears all counters.
// ============================================================================
module nearest_downscale_to_rgb565
   import dsr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   cfg_type          cfg;
   ctrl_cmd_type     cmd;
   ctrl_status_type  status;
   logic             cfg_written;
   logic             div_done;
   logic [DIM_W-1:0] div_dividend, div_divisor, div_quotient, div_remainder;

   assign status.cfg_written = cfg_written;
   assign status.div_done    = div_done;

   dsr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .cfg         (cfg),
      .cfg_written (cfg_written)
   );

   dsr_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .done      (div_done)
   );

   dsr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   dsr_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .cmd           (cmd),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .div_dividend  (div_dividend),
      .div_divisor   (div_divisor),
      .div_quotient  (div_quotient),
      .div_remainder (div_remainder)
   );

endmodule

/* hdl/dsr_csr.sv */
// ============================================================================
// dsr_csr - configuration registers
// APB-style register file holding frame sizes and the source pixel format.
// ============================================================================
module dsr_csr
   import dsr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg,
   output logic              cfg_written
);

   cfg_type          cfg_ff, cfg_in;
   logic [IDX_W-1:0] index;
   logic             wr_en;

   assign pready = 1'b1;
   assign index  = paddr[ADDR_W-1:2];
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_DST_WIDTH:    cfg_in.dst_width    = pwdata[CFG_W-1:0];
            REG_DST_HEIGHT:   cfg_in.dst_height   = pwdata[CFG_W-1:0];
            REG_SRC_WIDTH:    cfg_in.src_width    = pwdata[CFG_W-1:0];
            REG_SRC_HEIGHT:   cfg_in.src_height   = pwdata[CFG_W-1:0];
            REG_PIXEL_FORMAT: cfg_in.pixel_format = pwdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dst_width    <= RST_DST_WIDTH;
         cfg_ff.dst_height   <= RST_DST_HEIGHT;
         cfg_ff.src_width    <= RST_SRC_WIDTH;
         cfg_ff.src_height   <= RST_SRC_HEIGHT;
         cfg_ff.pixel_format <= FMT_XRGB8888;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (index)
         REG_DST_WIDTH:    prdata = DATA_W'(cfg_ff.dst_width);
         REG_DST_HEIGHT:   prdata = DATA_W'(cfg_ff.dst_height);
         REG_SRC_WIDTH:    prdata = DATA_W'(cfg_ff.src_width);
         REG_SRC_HEIGHT:   prdata = DATA_W'(cfg_ff.src_height);
         REG_PIXEL_FORMAT: prdata = DATA_W'(cfg_ff.pixel_format);
         default:          prdata = '0;
      endcase
   end

   assign cfg         = cfg_ff;
   assign cfg_written = wr_en;

endmodule

/* hdl/dsr_divider.sv */
// ============================================================================
// dsr_divider - iterative restoring divider
// One quotient bit per cycle; gives quotient and remainder of the frame ratios.
// ============================================================================
module dsr_divider
   import dsr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIM_W-1:0] dividend,
   input  logic [DIM_W-1:0] divisor,
   output logic [DIM_W-1:0] quotient,
   output logic [DIM_W-1:0] remainder,
   output logic             done
);

   logic [DIM_W-1:0]     rem_ff, rem_in;
   logic [DIM_W-1:0]     quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIM_W:0]       shifted;
   logic                 ge;

   assign shifted = {rem_ff, quo_ff[DIM_W-1]};
   assign ge      = (shifted >= {1'b0, divisor});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = DIV_CNT_W'(DIM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? DIM_W'(shifted - {1'b0, divisor}) : DIM_W'(shifted);
         quo_in = {quo_ff[DIM_W-2:0], ge};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

   assert property (@(posedge clock) disable iff (reset)
                    start && !reset |=> busy_ff && !done_ff)
      else $error("divider did not start on request");

endmodule

/* hdl/dsr_ctrl.sv */
// ============================================================================
// dsr_ctrl - sequencing controller
// Works out both frame ratios after reset and after every register write,
// then lets the datapath run.
// ============================================================================
module dsr_ctrl
   import dsr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      if (status.cfg_written) begin
         // any write may change a ratio: recompute both
         state_in = ST_LOAD_COL;
      end else begin
         unique case (state_ff)
            ST_LOAD_COL: state_in = ST_WAIT_COL;
            ST_WAIT_COL: if (status.div_done) state_in = ST_LOAD_ROW;
            ST_LOAD_ROW: state_in = ST_WAIT_ROW;
            ST_WAIT_ROW: if (status.div_done) state_in = ST_RUN;
            ST_RUN:      state_in = ST_RUN;
            default:     state_in = ST_LOAD_COL;
         endcase
      end
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_LOAD_COL: cmd.div_start = 1'b1;
         ST_WAIT_COL: cmd.latch_col = status.div_done;
         ST_LOAD_ROW: begin
            cmd.div_start = 1'b1;
            cmd.sel_row   = 1'b1;
         end
         ST_WAIT_ROW: begin
            cmd.sel_row   = 1'b1;
            cmd.latch_row = status.div_done;
         end
         ST_RUN:      cmd.run = 1'b1;
         default:     cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD_COL;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hdl/dsr_datapath.sv */
// ============================================================================
// dsr_datapath - position counters, sampling targets and pixel conversion
// Steps the source position once per transfer, the destination position along
// the sampled grid, and registers each sampled pixel for the result channel.
// ============================================================================
module dsr_datapath
   import dsr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  ctrl_cmd_type     cmd,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   output logic [DIM_W-1:0] div_dividend,
   output logic [DIM_W-1:0] div_divisor,
   input  logic [DIM_W-1:0] div_quotient,
   input  logic [DIM_W-1:0] div_remainder
);

   logic [DIM_W-1:0] dw, dh, sw, sh, sw_raw, sh_raw;

   logic [DIM_W-1:0] col_q_ff, col_r_ff, row_q_ff, row_r_ff;

   logic [CNT_W-1:0] src_col_ff, src_col_in, src_row_ff, src_row_in;
   logic [CNT_W-1:0] dst_col_ff, dst_col_in, dst_row_ff, dst_row_in;
   logic [DIM_W-1:0] col_target_ff, col_target_in, row_target_ff, row_target_in;
   logic [DIM_W-1:0] col_rem_ff, col_rem_in, row_rem_ff, row_rem_in;

   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             take;
   logic             emit;

   always_comb begin
      dw     = eff_dim(cfg.dst_width);
      dh     = eff_dim(cfg.dst_height);
      sw_raw = eff_dim(cfg.src_width);
      sh_raw = eff_dim(cfg.src_height);
      sw     = (sw_raw < dw) ? dw : sw_raw;
      sh     = (sh_raw < dh) ? dh : sh_raw;
   end

   assign div_dividend = cmd.sel_row ? sh : sw;
   assign div_divisor  = cmd.sel_row ? dh : dw;

   always_ff @(posedge clock) begin
      if (cmd.latch_col) begin
         col_q_ff <= div_quotient;
         col_r_ff <= div_remainder;
      end
      if (cmd.latch_row) begin
         row_q_ff <= div_quotient;
         row_r_ff <= div_remainder;
      end
   end

   assign req_stall = !cmd.run || (rsp_valid_ff && rsp_stall);
   assign take      = req_valid && !req_stall;

   always_comb begin
      logic [CNT_W-1:0] scol, srow, dcol, drow;
      logic [DIM_W-1:0] ctgt, rtgt, crem, rrem;
      adv_type          adv;

      // frame start clears every counter before this pixel is looked at
      if (req_data.frame_start) begin
         scol = '0; srow = '0; dcol = '0; drow = '0;
         ctgt = '0; rtgt = '0; crem = '0; rrem = '0;
      end else begin
         scol = src_col_ff; srow = src_row_ff;
         dcol = dst_col_ff; drow = dst_row_ff;
         ctgt = col_target_ff; rtgt = row_target_ff;
         crem = col_rem_ff;    rrem = row_rem_ff;
      end

      emit = (DIM_W'(srow) == rtgt) && (DIM_W'(scol) == ctgt) &&
             (DIM_W'(dcol) < dw) && (DIM_W'(drow) < dh);

      src_col_in    = scol;
      src_row_in    = srow;
      dst_col_in    = dcol;
      dst_row_in    = drow;
      col_target_in = ctgt;
      row_target_in = rtgt;
      col_rem_in    = crem;
      row_rem_in    = rrem;

      rsp_data_in.out_pixel = to_rgb565(cfg.pixel_format, req_data.src_pixel);
      rsp_data_in.frame_end = (DIM_W'(dcol) == dw - DIM_W'(1)) &&
                              (DIM_W'(drow) == dh - DIM_W'(1));

      if (emit && (DIM_W'(dcol) + DIM_W'(1) < dw)) begin
         dst_col_in    = dcol + CNT_W'(1);
         adv           = advance(ctgt, crem, col_q_ff, col_r_ff, dw);
         col_target_in = adv.target;
         col_rem_in    = adv.rem;
      end else begin
         adv = '0;
      end

      if (DIM_W'(scol) + DIM_W'(1) >= sw) begin
         // end of source row: restart the column walk
         src_col_in    = '0;
         dst_col_in    = '0;
         col_target_in = '0;
         col_rem_in    = '0;
         if (DIM_W'(srow) + DIM_W'(1) >= sh) begin
            src_row_in    = '0;
            dst_row_in    = '0;
            row_target_in = '0;
            row_rem_in    = '0;
         end else begin
            src_row_in = srow + CNT_W'(1);
            if ((DIM_W'(srow) == rtgt) && (DIM_W'(drow) + DIM_W'(1) < dh)) begin
               dst_row_in    = drow + CNT_W'(1);
               adv           = advance(rtgt, rrem, row_q_ff, row_r_ff, dh);
               row_target_in = adv.target;
               row_rem_in    = adv.rem;
            end
         end
      end else begin
         src_col_in = scol + CNT_W'(1);
      end

      if (take && emit)
         rsp_valid_in = 1'b1;
      else if (!rsp_stall)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff    <= '0;
         src_row_ff    <= '0;
         dst_col_ff    <= '0;
         dst_row_ff    <= '0;
         col_target_ff <= '0;
         row_target_ff <= '0;
         col_rem_ff    <= '0;
         row_rem_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (take) begin
            src_col_ff    <= src_col_in;
            src_row_ff    <= src_row_in;
            dst_col_ff    <= dst_col_in;
            dst_row_ff    <= dst_row_in;
            col_target_ff <= col_target_in;
            row_target_ff <= row_target_in;
            col_rem_ff    <= col_rem_in;
            row_rem_ff    <= row_rem_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      // hold the payload while the result waits
      if (take && emit)
         rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset) take |-> cmd.run)
      else $error("pixel taken while ratios are not ready");

   assert property (@(posedge clock) disable iff (reset)
                    take && emit |=> rsp_valid_ff)
      else $error("sampled pixel did not reach the result register");

   assert property (@(posedge clock) disable iff (reset)
                    cmd.run |-> (col_r_ff < dw) && (row_r_ff < dh))
      else $error("ratio remainder out of range while running");

endmodule

/* verif/nearest_downscale_to_rgb565_test.sv */
// ============================================================================
// nearest_downscale_to_rgb565_test - self-checking bench for the downscaler
// A short directed table, then random frames under many size and format
// settings. Every kept pixel is predicted in the bench and compared field by
// field with the response channel, while both sides idle and stall at random.
// ============================================================================
module nearest_downscale_to_rgb565_test
   import dsr_pkg::*;
;

   localparam int IDLE_PERCENT   = 17;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES         = 14;
   localparam int HOLD_PHASE     = 2;
   localparam int PAUSE_PHASE    = 5;
   localparam int STEADY_FIRST   = 7;
   localparam int STEADY_LAST    = 8;
   localparam int PLAN_ROWS      = 47;

   typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      logic [IDX_W-1:0] idx;
      logic [CFG_W-1:0] value;
      req_type          px;
      logic             typed;
      rsp_type          want;
   } stim_row_type;

   // Typed results only where the answer is plain: first pixel of a frame,
   // one-pixel frames, colour extremes
   localparam stim_row_type PLAN [PLAN_ROWS] = '{
      '{ROW_PIXEL, REG_DST_WIDTH, 13'd0, '{32'hFFFFFFFF, 1'b1}, 1'b1, '{16'hFFFF, 1'b0}},
      '{ROW_PIXEL, REG_DST_WIDTH, 13'd0, '{32'h00000000, 1'b0}, 1'b0, '0},
      '{ROW_PIXEL, REG_DST_WIDTH, 13'd0, '{32'hFF123456, 1'b0}, 1'b0, '0},
      '{ROW_PIXEL, REG_DST_WIDTH, 13'd0, '{32'h00FFFFFF, 1'b1}, 1'b1, '{16'hFFFF, 1'b0}},
      '{ROW_PIXEL, REG_DST_WIDTH, 13'd0, '{32'hFF000000, 1'b1}, 1'b1, '{16'h0000, 1'b0}},
      '{ROW_PIXEL, REG_DST_WIDTH, 13'd0, '{32'h00F80000, 1'b1}, 1'b1, '{16'hF800, 1'b0}},
      '{ROW_PIXEL, REG_DST_WIDTH, 13'd0, '{32'h0000FC00, 1'b1}, 1'b1, '{16'h07E0, 1'b0}},
      '{ROW_PIXEL, REG_DST_WIDTH, 13'd0, '{32'h000000F8, 1'b1}, 1'b1, '{16'h001F, 1'b0}},
      '{ROW_PIXEL, REG_DST_WIDTH, 13'd0, '{32'h00070307, 1'b1}, 1'b1, '{16'h0000, 1'b0}},
      '{ROW_PIXEL, REG_DST_WIDTH, 13'd0, '{32'hA5A5A5A5, 1'b0}, 1'b0, '0},
      '{ROW_WRITE, REG_PIXEL_FORMAT, 13'(FMT_RGB565), '0, 1'b0, '0},
      '{ROW_PIXEL, REG_DST_WIDTH, 13'd0, '{32'hFFFF0000, 1'b1}, 1'b1, '{16'h0000, 1'b0}},
      '{ROW_PIXEL, REG_DST_WIDTH, 13'd0, '{32'h0000FFFF, 1'b1}, 1'b1, '{16'hFFFF, 1'b0}},
      '{ROW_PIXEL, REG_DST_WIDTH, 13'd0, '{32'hABCD1234, 1'b0}, 1'b0, '0},
      '{ROW_WRITE, REG_DST_WIDTH, 13'd1, '0, 1'b0, '0},
      '{ROW_WRITE, REG_DST_HEIGHT, 13'd1, '0, 1'b0, '0},
      '{ROW_WRITE, REG_SRC_WIDTH, 13'd1, '0, 1'b0, '0},
      '{ROW_WRITE, REG_SRC_HEIGHT, 13'd1, '0, 1'b0, '0},
      '{ROW_PIXEL, REG_DST_WIDTH, 13'd0, '{32'h00008001, 1'b1}, 1'b1, '{16'h8001, 1'b1}},
      '{ROW_PIXEL, REG_DST_WIDTH, 13'd0, '{32'hFFFF7FFE, 1'b0}, 1'b1, '{16'h7FFE, 1'b1}},
      '{ROW_WRITE, REG_DST_WIDTH, 13'd0, '0, 1'b0, '0},
      '{ROW_WRITE, REG_DST_HEIGHT, 13'd0, '0, 1'b0, '0},
      '{ROW_WRITE, REG_SRC_WIDTH, 13'd0, '0, 1'b0, '0},
      '{ROW_WRITE, REG_SRC_HEIGHT, 13'd0, '0, 1'b0, '0},
      '{ROW_PIXEL, REG_DST_WIDTH, 13'd0, '{32'h00005555, 1'b0}, 1'b1, '{16'h5555, 1'b1}},
      '{ROW_PIXEL, REG_DST_WIDTH, 13'd0, '{32'h0000AAAA, 1'b1}, 1'b1, '{16'hAAAA, 1'b1}},
      '{ROW_WRITE, REG_DST_WIDTH, 13'd8191, '0, 1'b0, '0},
      '{ROW_WRITE, REG_DST_HEIGHT, 13'd4096, '0, 1'b0, '0},
      '{ROW_WRITE, REG_SRC_WIDTH, 13'd8191, '0, 1'b0, '0},
      '{ROW_WRITE, REG_SRC_HEIGHT, 13'd8191, '0, 1'b0, '0},
      '{ROW_WRITE, REG_PIXEL_FORMAT, 13'(FMT_XRGB8888), '0, 1'b0, '0},
      '{ROW_PIXEL, REG_DST_WIDTH, 13'd0, '{32'h00FF00FF, 1'b1}, 1'b1, '{16'hF81F, 1'b0}},
      '{ROW_PIXEL, REG_DST_WIDTH, 13'd0, '{32'h12345678, 1'b0}, 1'b0, '0},
      '{ROW_PIXEL, REG_DST_WIDTH, 13'd0, '{32'h87654321, 1'b0}, 1'b0, '0},
      '{ROW_WRITE, REG_DST_WIDTH, 13'd3, '0, 1'b0, '0},
      '{ROW_WRITE, REG_DST_HEIGHT, 13'd2, '0, 1'b0, '0},
      '{ROW_WRITE, REG_SRC_WIDTH, 13'd4096, '0, 1'b0, '0},
      '{ROW_WRITE, REG_SRC_HEIGHT, 13'd5, '0, 1'b0, '0},
      '{ROW_PIXEL, REG_DST_WIDTH, 13'd0, '{32'hFFFFFFFF, 1'b1}, 1'b1, '{16'hFFFF, 1'b0}},
      '{ROW_PIXEL, REG_DST_WIDTH, 13'd0, '{32'h00000001, 1'b0}, 1'b0, '0},
      '{ROW_WRITE, REG_DST_WIDTH, 13'd4, '0, 1'b0, '0},
      '{ROW_WRITE, REG_DST_HEIGHT, 13'd2, '0, 1'b0, '0},
      '{ROW_WRITE, REG_SRC_WIDTH, 13'd1, '0, 1'b0, '0},
      '{ROW_WRITE, REG_SRC_HEIGHT, 13'd1, '0, 1'b0, '0},
      '{ROW_PIXEL, REG_DST_WIDTH, 13'd0, '{32'h00C0FFEE, 1'b1}, 1'b1, '{16'hC7FD, 1'b0}},
      '{ROW_PIXEL, REG_DST_WIDTH, 13'd0, '{32'h00000000, 1'b0}, 1'b0, '0},
      '{ROW_PIXEL, REG_DST_WIDTH, 13'd0, '{32'h7FFFFFFF, 1'b0}, 1'b0, '0}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_data;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   // Register image and sampling position as the bench sees them
   logic [CFG_W-1:0] size_reg [2**IDX_W];
   logic             fmt_reg;
   int unsigned      src_x, src_y, dst_x, dst_y, tap_x, tap_y, frac_x, frac_y;

   rsp_type     pending_pixels [$];
   rsp_type     due;
   int unsigned mismatches = 0;
   int unsigned pixels_sent = 0;
   int unsigned results_seen = 0;
   int unsigned reg_writes = 0;
   int unsigned idle_cycles = 0;
   int unsigned hold_left = 0;
   bit          hold_request = 1'b0;
   bit          steady = 1'b0;

   nearest_downscale_to_rgb565 dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void flag_error(string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at %0t: %s", $realtime, msg);
   endfunction

   function automatic int unsigned clamp_size(logic [CFG_W-1:0] v);
      if (v == '0)
         return 1;
      if (int'(v) > MAX_DIM)
         return MAX_DIM;
      return int'(v);
   endfunction

   function automatic logic [15:0] pack565(logic [31:0] p);
      if (fmt_reg == FMT_RGB565)
         return p[15:0];
      return {p[23:19], p[15:10], p[7:3]};
   endfunction

   // Move a sampling tap on by s/d, carrying the fraction in units of 1/d
   function automatic int unsigned step_target(int unsigned tap, inout int unsigned frac,
                                               input int unsigned s, input int unsigned d);
      tap += s / d;
      frac += s % d;
      if (frac >= d) begin
         frac -= d;
         tap++;
      end
      return tap;
   endfunction

   function automatic void clear_position();
      src_x = 0; src_y = 0; dst_x = 0; dst_y = 0;
      tap_x = 0; tap_y = 0; frac_x = 0; frac_y = 0;
   endfunction

   function automatic bit scale_pixel(input req_type px, output rsp_type res);
      int unsigned dw, dh, sw, sh;
      bit          kept, row_hit;
      dw = clamp_size(size_reg[REG_DST_WIDTH]);
      dh = clamp_size(size_reg[REG_DST_HEIGHT]);
      sw = clamp_size(size_reg[REG_SRC_WIDTH]);
      sh = clamp_size(size_reg[REG_SRC_HEIGHT]);
      if (sw < dw)
         sw = dw;
      if (sh < dh)
         sh = dh;
      if (px.frame_start)
         clear_position();
      res = '0;
      kept = src_y == tap_y && src_x == tap_x && dst_x < dw && dst_y < dh;
      if (kept) begin
         res.out_pixel = pack565(px.src_pixel);
         res.frame_end = dst_x == dw - 1 && dst_y == dh - 1;
         if (dst_x + 1 < dw) begin
            dst_x++;
            tap_x = step_target(tap_x, frac_x, sw, dw);
         end
      end
      if (src_x + 1 >= sw) begin
         row_hit = src_y == tap_y;
         src_x = 0; dst_x = 0; tap_x = 0; frac_x = 0;
         if (src_y + 1 >= sh) begin
            clear_position();
         end else begin
            src_y++;
            if (row_hit && dst_y + 1 < dh) begin
               dst_y++;
               tap_y = step_target(tap_y, frac_y, sh, dh);
            end
         end
      end else begin
         src_x++;
      end
      return kept;
   endfunction

   function automatic logic [CFG_W-1:0] extreme_size();
      case ($urandom_range(4))
         0: return '0;
         1: return CFG_W'(1);
         2: return CFG_W'(MAX_DIM);
         3: return CFG_W'($urandom_range(MAX_DIM + 1, 8191));
         default: return CFG_W'($urandom_range(1, MAX_DIM));
      endcase
   endfunction

   // Write one register, then read it back
   task automatic csr_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      logic [DATA_W-1:0] word;
      word = (idx == REG_PIXEL_FORMAT) ? DATA_W'(value[0]) : DATA_W'(value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_W'({idx, 2'b00});
      pwdata <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == REG_PIXEL_FORMAT)
         fmt_reg = value[0];
      else
         size_reg[idx] = value;
      reg_writes++;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== word)
         flag_error($sformatf("register %0d reads %h, wrote %h", idx, prdata, word));
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic send_pixel(req_type px, bit typed, rsp_type typed_rsp);
      rsp_type guess;
      bit      kept;
      if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < IDLE_PERCENT);
      end
      req_valid <= 1'b1;
      req_data <= px;
      do @(posedge clock); while (req_stall);
      kept = scale_pixel(px, guess);
      if (typed)
         pending_pixels.push_back(typed_rsp);
      else if (kept)
         pending_pixels.push_back(guess);
      pixels_sent++;
   endtask

   // Hold the input until every predicted pixel has arrived, then settle
   task automatic finish_results(int unsigned extra);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_pixels.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   // Response side: check each transfer, then choose the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_pixels.size() == 0) begin
            flag_error($sformatf("pixel %h end %b with nothing expected",
                                 rsp_data.out_pixel, rsp_data.frame_end));
         end else begin
            due = pending_pixels.pop_front();
            if (rsp_data.out_pixel !== due.out_pixel)
               flag_error($sformatf("out_pixel %h, expected %h",
                                    rsp_data.out_pixel, due.out_pixel));
            if (rsp_data.frame_end !== due.frame_end)
               flag_error($sformatf("frame_end %b, expected %b on pixel %h",
                                    rsp_data.frame_end, due.frame_end, due.out_pixel));
         end
      end
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      rsp_stall <= hold_left != 0 || (!steady && $urandom_range(99) < IDLE_PERCENT);
      if (hold_left != 0)
         hold_left--;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("no transfer for %0d cycles, %0d pixels still expected",
                  idle_cycles, pending_pixels.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      logic [CFG_W-1:0] new_size [2**IDX_W];
      logic             new_fmt;
      req_type          px;
      int unsigned      budget, sent, frame_len, n, fw, fh;
      bit               big, paused;

      size_reg[REG_DST_WIDTH]  = RST_DST_WIDTH;
      size_reg[REG_DST_HEIGHT] = RST_DST_HEIGHT;
      size_reg[REG_SRC_WIDTH]  = RST_SRC_WIDTH;
      size_reg[REG_SRC_HEIGHT] = RST_SRC_HEIGHT;
      fmt_reg = FMT_XRGB8888;
      clear_position();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PLAN_ROWS; i++) begin
         if (PLAN[i].kind == ROW_WRITE) begin
            finish_results(SETTLE_CYCLES);
            csr_write(PLAN[i].idx, PLAN[i].value);
         end else begin
            send_pixel(PLAN[i].px, PLAN[i].typed, PLAN[i].want);
         end
      end

      paused = 1'b0;
      for (int phase = 0; phase < PHASES; phase++) begin
         finish_results(SETTLE_CYCLES);
         big = phase % 5 == 4;
         if (phase == HOLD_PHASE) begin
            // equal sizes keep every pixel, so the block fills while held
            new_size[REG_DST_WIDTH]  = CFG_W'($urandom_range(2, 12));
            new_size[REG_DST_HEIGHT] = CFG_W'($urandom_range(2, 8));
            new_size[REG_SRC_WIDTH]  = new_size[REG_DST_WIDTH];
            new_size[REG_SRC_HEIGHT] = new_size[REG_DST_HEIGHT];
         end else if (big) begin
            for (int k = 0; k < 4; k++)
               new_size[k] = extreme_size();
         end else begin
            new_size[REG_DST_WIDTH]  = CFG_W'($urandom_range(0, 10));
            new_size[REG_DST_HEIGHT] = CFG_W'($urandom_range(0, 8));
            new_size[REG_SRC_WIDTH]  = CFG_W'($urandom_range(0, 20));
            new_size[REG_SRC_HEIGHT] = CFG_W'($urandom_range(0, 16));
         end
         new_fmt = $urandom_range(1) ? FMT_XRGB8888 : FMT_RGB565;
         csr_write(REG_DST_WIDTH, new_size[REG_DST_WIDTH]);
         csr_write(REG_DST_HEIGHT, new_size[REG_DST_HEIGHT]);
         csr_write(REG_SRC_WIDTH, new_size[REG_SRC_WIDTH]);
         csr_write(REG_SRC_HEIGHT, new_size[REG_SRC_HEIGHT]);
         csr_write(REG_PIXEL_FORMAT, CFG_W'(new_fmt));

         fw = clamp_size(size_reg[REG_SRC_WIDTH]);
         if (fw < clamp_size(size_reg[REG_DST_WIDTH]))
            fw = clamp_size(size_reg[REG_DST_WIDTH]);
         fh = clamp_size(size_reg[REG_SRC_HEIGHT]);
         if (fh < clamp_size(size_reg[REG_DST_HEIGHT]))
            fh = clamp_size(size_reg[REG_DST_HEIGHT]);
         frame_len = fw * fh;

         if (phase == HOLD_PHASE)
            hold_request = 1'b1;
         steady = phase >= STEADY_FIRST && phase <= STEADY_LAST;
         budget = big ? 60 : 140;
         sent = 0;
         while (sent < budget) begin
            if (phase == PAUSE_PHASE && !paused && sent >= budget / 2) begin
               finish_results(0);
               paused = 1'b1;
            end
            if ($urandom_range(99) < 80) begin
               // whole frame; counters wrap, so frame_start is optional
               n = frame_len < budget - sent ? frame_len : budget - sent;
               for (int k = 0; k < n; k++) begin
                  px.src_pixel = $urandom;
                  px.frame_start = k == 0 && $urandom_range(9) < 7;
                  send_pixel(px, 1'b0, '0);
               end
            end else begin
               // broken frame: stray starts and truncation
               n = $urandom_range(1, 20);
               for (int k = 0; k < n; k++) begin
                  px.src_pixel = $urandom;
                  px.frame_start = $urandom_range(3) == 0;
                  send_pixel(px, 1'b0, '0);
               end
            end
            sent += n;
         end
         steady = 1'b0;
      end

      finish_results(SETTLE_CYCLES);
      $display("%0d source pixels, %0d downscaled pixels checked, %0d register writes",
               pixels_sent, results_seen, reg_writes);
      $display("sizes from 1x1 up to 4096 clamps, both source formats, hold-off and drain");
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

/* sim.f */
hdl/dsr_pkg.sv
hdl/dsr_csr.sv
hdl/dsr_divider.sv
hdl/dsr_ctrl.sv
hdl/dsr_datapath.sv
hdl/nearest_downscale_to_rgb565.sv
verif/nearest_downscale_to_rgb565_test.sv
